@@ design/ptt_pkg.sv @@
// shared types and constants for the periodic task timer table
// no dependencies; used by ptt_alu, ptt_table and periodic_task_timer_table
package ptt_pkg;

   // default table depth and the limit on due reports per dispatch
   localparam int DEF_NUM_TASKS = 8;
   localparam int MAX_RESULTS   = 8;

   // field widths
   localparam int ID_W     = 8;
   localparam int PERIOD_W = 16;
   localparam int COUNT_W  = 16;
   localparam int RES_W    = 8;
   localparam int OVF_W    = 10;
   localparam int NRES_W   = $clog2(MAX_RESULTS + 1);

   // reset value of the resolution register
   localparam logic [RES_W-1:0] RES_RESET = RES_W'(1);

   // request commands
   typedef enum logic [1:0] {
      CMD_START    = 2'd0,
      CMD_STOP     = 2'd1,
      CMD_OVERFLOW = 2'd2,
      CMD_DISPATCH = 2'd3
   } cmd_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   // one table entry as held in the entry memory
   typedef struct packed {
      logic [ID_W-1:0]     id;
      logic [PERIOD_W-1:0] period;
      logic                run_once;
      logic [COUNT_W-1:0]  count;
   } entry_type;

   // flags and next count from the shared entry unit
   typedef struct packed {
      logic               due;
      logic               match;
      logic [COUNT_W-1:0] count_inc;
   } alu_res_type;

endpackage

@@ design/periodic_task_timer_table.sv @@
// periodic task timer table: sequencer, control registers and response register
// depends on ptt_pkg, ptt_alu and ptt_table
//
//   port group   dir   handshake           payload
//   req_*        in    req_valid/req_stall  command, task_id, period, run_once
//   rsp_*        out   rsp_valid/rsp_stall  status, fired, fired_task_id, last
//   csr_*        in    csr_valid/csr_ready  resolution
//
// start and a non-ticking overflow go straight to the response; a ticking overflow visits every entry.
// stop visits entries until the id matches, then moves the tail entry into the freed slot;
// dispatch visits entries in turn and moves the tail entry into each slot a one-shot frees.
// entries are visited one at a time through the single registered read port of the entry memory.
// reset is synchronous and active high; it empties the table and needs no sweep.
// a stalled response holds the sequencer only when it has a new result to load.
module periodic_task_timer_table #(
   parameter int NUM_TASKS = ptt_pkg::DEF_NUM_TASKS
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_command,
   input  logic [ptt_pkg::ID_W-1:0]        req_task_id,
   input  logic [ptt_pkg::PERIOD_W-1:0]    req_period,
   input  logic                            req_run_once,
   // response channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_fired,
   output logic [ptt_pkg::ID_W-1:0]        rsp_fired_task_id,
   output logic                            rsp_last,
   // resolution register write
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ptt_pkg::RES_W-1:0]       csr_resolution
);

   localparam int IdxW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int CntW = $clog2(NUM_TASKS + 1);

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_READ    = 6'b000010,
      S_EVAL    = 6'b000100,
      S_MOVE_RD = 6'b001000,
      S_MOVE_WR = 6'b010000,
      S_RESP    = 6'b100000
   } state_type;

   state_type                        state_ff, state_in;
   ptt_pkg::cmd_type                 cmd_ff, cmd_in;
   logic [ptt_pkg::ID_W-1:0]         id_ff, id_in;
   ptt_pkg::status_type              status_ff, status_in;
   logic [IdxW-1:0]                  idx_ff, idx_in;
   logic [CntW-1:0]                  active_ff, active_in;
   logic [ptt_pkg::OVF_W-1:0]        ovf_ff, ovf_in;
   logic [ptt_pkg::RES_W-1:0]        res_ff;
   logic [ptt_pkg::NRES_W-1:0]       n_ff, n_in;
   logic                             pending_ff, pending_in;
   logic [ptt_pkg::ID_W-1:0]         pend_id_ff, pend_id_in;

   logic                             rsp_valid_ff, rsp_valid_in;
   ptt_pkg::status_type              rsp_status_ff, rsp_status_in;
   logic                             rsp_fired_ff, rsp_fired_in;
   logic [ptt_pkg::ID_W-1:0]         rsp_id_ff, rsp_id_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             wr_en;
   logic [IdxW-1:0]                  wr_addr;
   ptt_pkg::entry_type               wr_data;
   logic                             rd_en;
   logic [IdxW-1:0]                  rd_addr;
   ptt_pkg::entry_type               rd_data;
   ptt_pkg::alu_res_type             alu_res;

   logic                             out_free;
   logic                             last_slot;
   logic                             table_full;
   logic [ptt_pkg::OVF_W-1:0]        ovf_next;
   logic [ptt_pkg::OVF_W-1:0]        ovf_target;
   logic [ptt_pkg::RES_W-1:0]        res_eff;
   logic [ptt_pkg::NRES_W-1:0]       n_plus;

   // entry memory and shared entry unit
   ptt_table #(
      .NUM_TASKS (NUM_TASKS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ptt_alu u_alu (
      .entry  (rd_data),
      .key_id (id_ff),
      .res    (alu_res)
   );

   // handshakes
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // helpers for the sequencer
   assign last_slot  = ((CntW'(idx_ff) + CntW'(1)) == active_ff);
   assign table_full = (active_ff == CntW'(NUM_TASKS));
   assign res_eff    = (res_ff == '0) ? ptt_pkg::RES_W'(1) : res_ff;
   assign ovf_target = {res_eff, 2'b00};
   assign ovf_next   = ovf_ff + ptt_pkg::OVF_W'(1);
   assign n_plus     = n_ff + ptt_pkg::NRES_W'(1);

   // sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      status_in     = status_ff;
      idx_in        = idx_ff;
      active_in     = active_ff;
      ovf_in        = ovf_ff;
      n_in          = n_ff;
      pending_in    = pending_ff;
      pend_id_in    = pend_id_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_fired_in  = rsp_fired_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_last_in   = rsp_last_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = rd_data;
      rd_en         = 1'b0;
      rd_addr       = idx_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = ptt_pkg::cmd_type'(req_command);
               id_in      = req_task_id;
               idx_in     = '0;
               n_in       = '0;
               pending_in = 1'b0;
               status_in  = ptt_pkg::ST_OK;
               case (ptt_pkg::cmd_type'(req_command))
                  ptt_pkg::CMD_START: begin
                     if (table_full) begin
                        status_in = ptt_pkg::ST_FULL;
                     end else begin
                        wr_en            = 1'b1;
                        wr_addr          = IdxW'(active_ff);
                        wr_data.id       = req_task_id;
                        wr_data.period   = req_period;
                        wr_data.run_once = req_run_once;
                        wr_data.count    = '0;
                        active_in        = active_ff + CntW'(1);
                     end
                     state_in = S_RESP;
                  end
                  ptt_pkg::CMD_STOP: begin
                     if (active_ff == '0) begin
                        status_in = ptt_pkg::ST_NOT_FOUND;
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_READ;
                     end
                  end
                  ptt_pkg::CMD_OVERFLOW: begin
                     if (ovf_next >= ovf_target) begin
                        ovf_in   = '0;
                        state_in = (active_ff == '0) ? S_RESP : S_READ;
                     end else begin
                        ovf_in   = ovf_next;
                        state_in = S_RESP;
                     end
                  end
                  ptt_pkg::CMD_DISPATCH: begin
                     state_in = (active_ff == '0) ? S_RESP : S_READ;
                  end
               endcase
            end
         end

         S_READ: begin
            rd_en    = 1'b1;
            state_in = S_EVAL;
         end

         S_EVAL: begin
            case (cmd_ff)
               ptt_pkg::CMD_OVERFLOW: begin
                  // tick: bump this entry's count
                  wr_en         = 1'b1;
                  wr_data.count = alu_res.count_inc;
                  idx_in        = idx_ff + IdxW'(1);
                  state_in      = last_slot ? S_RESP : S_READ;
               end
               ptt_pkg::CMD_STOP: begin
                  if (alu_res.match) begin
                     if (last_slot) begin
                        active_in = active_ff - CntW'(1);
                        state_in  = S_RESP;
                     end else begin
                        state_in = S_MOVE_RD;
                     end
                  end else if (last_slot) begin
                     status_in = ptt_pkg::ST_NOT_FOUND;
                     state_in  = S_RESP;
                  end else begin
                     idx_in   = idx_ff + IdxW'(1);
                     state_in = S_READ;
                  end
               end
               ptt_pkg::CMD_DISPATCH: begin
                  if (!alu_res.due) begin
                     idx_in   = idx_ff + IdxW'(1);
                     state_in = last_slot ? S_RESP : S_READ;
                  end else if (!pending_ff || out_free) begin
                     // the previous due entry goes out now, this one waits
                     if (pending_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ptt_pkg::ST_OK;
                        rsp_fired_in  = 1'b1;
                        rsp_id_in     = pend_id_ff;
                        rsp_last_in   = 1'b0;
                     end
                     pending_in = 1'b1;
                     pend_id_in = rd_data.id;
                     n_in       = n_plus;
                     if (rd_data.run_once) begin
                        if (last_slot) begin
                           active_in = active_ff - CntW'(1);
                           state_in  = S_RESP;
                        end else begin
                           state_in = S_MOVE_RD;
                        end
                     end else begin
                        wr_en         = 1'b1;
                        wr_data.count = '0;
                        idx_in        = idx_ff + IdxW'(1);
                        state_in      = (last_slot ||
                                         n_plus == ptt_pkg::NRES_W'(ptt_pkg::MAX_RESULTS))
                                        ? S_RESP : S_READ;
                     end
                  end
               end
               ptt_pkg::CMD_START: begin
                  state_in = S_RESP;
               end
            endcase
         end

         S_MOVE_RD: begin
            // fetch the tail entry
            rd_en    = 1'b1;
            rd_addr  = IdxW'(active_ff - CntW'(1));
            state_in = S_MOVE_WR;
         end

         S_MOVE_WR: begin
            // tail entry, count included, fills the freed slot
            wr_en     = 1'b1;
            active_in = active_ff - CntW'(1);
            if (cmd_ff == ptt_pkg::CMD_DISPATCH &&
                n_ff != ptt_pkg::NRES_W'(ptt_pkg::MAX_RESULTS)) begin
               state_in = S_READ;
            end else begin
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_fired_in  = (cmd_ff == ptt_pkg::CMD_DISPATCH) && pending_ff;
               rsp_id_in     = ((cmd_ff == ptt_pkg::CMD_DISPATCH) && pending_ff)
                               ? pend_id_ff : '0;
               rsp_last_in   = 1'b1;
               pending_in    = 1'b0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         active_ff    <= '0;
         ovf_ff       <= '0;
         res_ff       <= ptt_pkg::RES_RESET;
         n_ff         <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         ovf_ff       <= ovf_in;
         n_ff         <= n_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            res_ff <= csr_resolution;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      id_ff         <= id_in;
      status_ff     <= status_in;
      idx_ff        <= idx_in;
      pend_id_ff    <= pend_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_fired_ff  <= rsp_fired_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // response outputs
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_fired         = rsp_fired_ff;
   assign rsp_fired_task_id = rsp_id_ff;
   assign rsp_last          = rsp_last_ff;

   // the table never holds more entries than it has slots
   a_active_bound: assert property (@(posedge clock) disable iff (reset)
      active_ff <= CntW'(NUM_TASKS))
      else $error("active entry count beyond table depth");

   // a dispatch never reports more than the result limit
   a_result_bound: assert property (@(posedge clock) disable iff (reset)
      n_ff <= ptt_pkg::NRES_W'(ptt_pkg::MAX_RESULTS))
      else $error("dispatch result count beyond limit");

   // the entry count moves by at most one per cycle
   a_active_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (active_ff == $past(active_ff) ||
                         active_ff == $past(active_ff) + CntW'(1) ||
                         active_ff == $past(active_ff) - CntW'(1)))
      else $error("entry count jumped");

   // no due report is left behind when the sequencer goes idle
   a_no_pending_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pending_ff)
      else $error("pending due report while idle");

   // a response with last clear only comes from a dispatch that carries on
   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_in && !rsp_last_in && !(rsp_valid_ff && rsp_stall))
         |=> state_ff != S_IDLE)
      else $error("intermediate dispatch result without a following one");

endmodule

@@ design/ptt_alu.sv @@
// shared entry unit: id compare, due window test and saturating count increment
// depends on ptt_pkg
module ptt_alu (
   input  ptt_pkg::entry_type           entry,
   input  logic [ptt_pkg::ID_W-1:0]     key_id,
   output ptt_pkg::alu_res_type         res
);

   logic [ptt_pkg::COUNT_W:0]  count_ext;
   logic [ptt_pkg::PERIOD_W:0] twice_period;

   assign count_ext    = {1'b0, entry.count};
   assign twice_period = {entry.period, 1'b0};

   // due when period <= count < 2 * period; a zero period never falls due
   assign res.due = (entry.count >= entry.period) && (count_ext < twice_period);

   // id compare for stop
   assign res.match = (entry.id == key_id);

   // count sticks at its maximum
   assign res.count_inc = (&entry.count) ? entry.count
                                         : entry.count + ptt_pkg::COUNT_W'(1);

endmodule

@@ design/ptt_table.sv @@
// entry memory of the timer table: one write port, one registered read port
// depends on ptt_pkg
module ptt_table #(
   parameter int NUM_TASKS = ptt_pkg::DEF_NUM_TASKS
) (
   input  logic                                                  clock,
   input  logic                                                  wr_en,
   input  logic [((NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1)-1:0] wr_addr,
   input  ptt_pkg::entry_type                                    wr_data,
   input  logic                                                  rd_en,
   input  logic [((NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1)-1:0] rd_addr,
   output ptt_pkg::entry_type                                    rd_data
);

   ptt_pkg::entry_type mem [NUM_TASKS];
   ptt_pkg::entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sim/tb_periodic_task_timer_table.sv @@
// self-checking testbench for the periodic task timer table
// depends on ptt_pkg and periodic_task_timer_table; drives random idling on both channels
module tb_periodic_task_timer_table;

   localparam int NUM_TASKS = ptt_pkg::DEF_NUM_TASKS;

   // one expected response transaction
   typedef struct packed {
      ptt_pkg::status_type      status;
      logic                     fired;
      logic [ptt_pkg::ID_W-1:0] task_id;
      logic                     last;
   } timer_rsp_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic                         req_stall;
   logic [1:0]                   req_command = ptt_pkg::CMD_OVERFLOW;
   logic [ptt_pkg::ID_W-1:0]     req_task_id = '0;
   logic [ptt_pkg::PERIOD_W-1:0] req_period = '0;
   logic                         req_run_once = 1'b0;
   logic                         rsp_valid;
   logic                         rsp_stall = 1'b0;
   logic [1:0]                   rsp_status;
   logic                         rsp_fired;
   logic [ptt_pkg::ID_W-1:0]     rsp_fired_task_id;
   logic                         rsp_last;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [ptt_pkg::RES_W-1:0]    csr_resolution = ptt_pkg::RES_RESET;

   // shadow copy of the timer table
   logic [ptt_pkg::ID_W-1:0]     tbl_id     [NUM_TASKS];
   logic [ptt_pkg::PERIOD_W-1:0] tbl_period [NUM_TASKS];
   logic                         tbl_shot   [NUM_TASKS];
   logic [ptt_pkg::COUNT_W-1:0]  tbl_count  [NUM_TASKS];
   int                           tbl_size = 0;
   int                           overflows_seen = 0;
   int                           tick_groups = 1;

   timer_rsp_type pending_responses[$];
   timer_rsp_type want;
   logic          steady = 1'b0;
   int            mismatch_count = 0;
   int            items_sent = 0;
   int            rsp_checked = 0;
   int            due_seen = 0;
   int            full_seen = 0;
   int            missing_seen = 0;

   periodic_task_timer_table DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_task_id(req_task_id), .req_period(req_period), .req_run_once(req_run_once),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_fired(rsp_fired), .rsp_fired_task_id(rsp_fired_task_id), .rsp_last(rsp_last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_resolution(csr_resolution)
   );

   // clock, period 2
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // mismatch reporting
   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic void queue_response(input ptt_pkg::status_type st, input logic fired,
                                          input logic [ptt_pkg::ID_W-1:0] id,
                                          input logic last);
      timer_rsp_type item;
      item.status  = st;
      item.fired   = fired;
      item.task_id = id;
      item.last    = last;
      pending_responses.push_back(item);
   endfunction

   // close a gap by moving the tail entry, with its count, into the slot
   function automatic void remove_entry(input int slot);
      int tail;
      tail = tbl_size - 1;
      tbl_id[slot]     = tbl_id[tail];
      tbl_period[slot] = tbl_period[tail];
      tbl_shot[slot]   = tbl_shot[tail];
      tbl_count[slot]  = tbl_count[tail];
      tbl_size         = tail;
   endfunction

   // advance the shadow table by one accepted request and queue its responses
   function automatic void predict_timer_responses(input ptt_pkg::cmd_type cmd,
                                                   input logic [ptt_pkg::ID_W-1:0] id,
                                                   input logic [ptt_pkg::PERIOD_W-1:0] per,
                                                   input logic shot);
      int slot;
      int fires;
      int goal;
      int cnt;
      int per_v;
      logic found;
      logic [ptt_pkg::ID_W-1:0] due_ids[$];
      case (cmd)
         ptt_pkg::CMD_START: begin
            if (tbl_size >= NUM_TASKS) begin
               queue_response(ptt_pkg::ST_FULL, 1'b0, '0, 1'b1);
            end else begin
               tbl_id[tbl_size]     = id;
               tbl_period[tbl_size] = per;
               tbl_shot[tbl_size]   = shot;
               tbl_count[tbl_size]  = '0;
               tbl_size++;
               queue_response(ptt_pkg::ST_OK, 1'b0, '0, 1'b1);
            end
         end
         ptt_pkg::CMD_STOP: begin
            found = 1'b0;
            for (slot = 0; slot < tbl_size && !found; slot++) begin
               if (tbl_id[slot] == id) begin
                  remove_entry(slot);
                  found = 1'b1;
               end
            end
            queue_response(found ? ptt_pkg::ST_OK : ptt_pkg::ST_NOT_FOUND, 1'b0, '0, 1'b1);
         end
         ptt_pkg::CMD_OVERFLOW: begin
            goal = 4 * ((tick_groups == 0) ? 1 : tick_groups);
            overflows_seen = (overflows_seen + 1) & 10'h3FF;
            if (overflows_seen >= goal) begin
               overflows_seen = 0;
               for (slot = 0; slot < tbl_size; slot++)
                  if (tbl_count[slot] != {ptt_pkg::COUNT_W{1'b1}}) tbl_count[slot]++;
            end
            queue_response(ptt_pkg::ST_OK, 1'b0, '0, 1'b1);
         end
         default: begin
            // dispatch: an entry moved in by a one-shot removal is examined in place
            slot  = 0;
            fires = 0;
            while (slot < tbl_size && fires < ptt_pkg::MAX_RESULTS) begin
               cnt   = int'(tbl_count[slot]);
               per_v = int'(tbl_period[slot]);
               if (cnt >= per_v && cnt < 2 * per_v) begin
                  due_ids.push_back(tbl_id[slot]);
                  fires++;
                  tbl_count[slot] = '0;
                  if (tbl_shot[slot]) remove_entry(slot);
                  else slot++;
               end else begin
                  slot++;
               end
            end
            if (fires == 0) queue_response(ptt_pkg::ST_OK, 1'b0, '0, 1'b1);
            for (slot = 0; slot < fires; slot++)
               queue_response(ptt_pkg::ST_OK, 1'b1, due_ids[slot], slot == fires - 1);
         end
      endcase
   endfunction

   // one request transaction, with an occasional idle gap before it
   task automatic send_request(input ptt_pkg::cmd_type cmd,
                               input logic [ptt_pkg::ID_W-1:0] id,
                               input logic [ptt_pkg::PERIOD_W-1:0] per, input logic shot);
      int gap;
      if (!steady && $urandom_range(99) < 15) begin
         gap = $urandom_range(4, 1);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_task_id  <= id;
      req_period   <= per;
      req_run_once <= shot;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_timer_responses(cmd, id, per, shot);
      items_sent++;
   endtask

   // hold off the sender until every queued response has been taken
   task automatic wait_for_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_responses.size() != 0) @(posedge clock);
   endtask

   task automatic write_resolution(input logic [ptt_pkg::RES_W-1:0] value);
      csr_resolution <= value;
      csr_valid      <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid   <= 1'b0;
      tick_groups = int'(value);
   endtask

   task automatic send_overflows(input int n);
      repeat (n)
         send_request(ptt_pkg::CMD_OVERFLOW, ptt_pkg::ID_W'($urandom),
                      ptt_pkg::PERIOD_W'($urandom), 1'($urandom));
   endtask

   // empty table: stop finds nothing, dispatch reports nothing due
   task automatic test_empty_table();
      send_request(ptt_pkg::CMD_STOP, 8'h00, 16'h0000, 1'b0);
      send_request(ptt_pkg::CMD_DISPATCH, 8'hFF, 16'hFFFF, 1'b1);
      send_overflows(1);
   endtask

   // fill to the limit with extreme fields, then full, duplicate stop and one-shot moves
   task automatic test_fill_and_dispatch();
      send_request(ptt_pkg::CMD_START, 8'h00, 16'h0000, 1'b0);
      send_request(ptt_pkg::CMD_START, 8'hFF, 16'hFFFF, 1'b1);
      send_request(ptt_pkg::CMD_START, 8'h01, 16'h0001, 1'b0);
      send_request(ptt_pkg::CMD_START, 8'h02, 16'h0002, 1'b1);
      send_request(ptt_pkg::CMD_START, 8'h03, 16'h0001, 1'b1);
      send_request(ptt_pkg::CMD_START, 8'h01, 16'h0003, 1'b0);
      send_request(ptt_pkg::CMD_START, 8'h04, 16'h0002, 1'b0);
      send_request(ptt_pkg::CMD_START, 8'h05, 16'h0001, 1'b1);
      send_request(ptt_pkg::CMD_START, 8'h06, 16'h0001, 1'b0);
      send_request(ptt_pkg::CMD_STOP, 8'h01, 16'h0000, 1'b0);
      send_request(ptt_pkg::CMD_STOP, 8'hC8, 16'h0000, 1'b0);
      send_overflows(4);
      send_request(ptt_pkg::CMD_DISPATCH, 8'h00, 16'h0000, 1'b0);
      send_overflows(8);
      send_request(ptt_pkg::CMD_DISPATCH, 8'h00, 16'h0000, 1'b0);
   endtask

   // lowering the resolution under the running overflow count, and resolution zero
   task automatic test_resolution_changes();
      wait_for_idle();
      write_resolution(8'd10);
      send_overflows(30);
      wait_for_idle();
      write_resolution(8'd2);
      send_overflows(1);
      send_request(ptt_pkg::CMD_DISPATCH, 8'h00, 16'h0000, 1'b0);
      wait_for_idle();
      write_resolution(8'd0);
      send_overflows(4);
      send_request(ptt_pkg::CMD_DISPATCH, 8'h00, 16'h0000, 1'b0);
      wait_for_idle();
      write_resolution(8'd255);
      send_overflows(4);
      wait_for_idle();
   endtask

   // back-to-back stretch on an entry whose period is at its maximum
   task automatic test_long_period();
      while (tbl_size > 0) send_request(ptt_pkg::CMD_STOP, tbl_id[0], 16'h0000, 1'b0);
      wait_for_idle();
      write_resolution(8'd1);
      steady = 1'b1;
      send_request(ptt_pkg::CMD_START, 8'hA5, 16'hFFFF, 1'b0);
      send_overflows(12);
      send_request(ptt_pkg::CMD_DISPATCH, 8'h00, 16'h0000, 1'b0);
      wait_for_idle();
      steady = 1'b0;
   endtask

   // random traffic, mostly small periods and a small pool of ids
   task automatic test_random_traffic();
      logic [ptt_pkg::RES_W-1:0] res_list[4];
      int phase;
      int pick;
      logic [ptt_pkg::ID_W-1:0] id;
      logic [ptt_pkg::PERIOD_W-1:0] per;
      res_list = '{8'd1, 8'd3, 8'd255, 8'd2};
      for (phase = 0; phase < 4; phase++) begin
         wait_for_idle();
         write_resolution(res_list[phase]);
         steady = (phase == 1);
         repeat (80) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
               id = ($urandom_range(3) == 0) ? ptt_pkg::ID_W'($urandom)
                                             : ptt_pkg::ID_W'($urandom_range(7));
               case ($urandom_range(9))
                  0: per = '0;
                  1: per = ptt_pkg::PERIOD_W'($urandom);
                  default: per = ptt_pkg::PERIOD_W'($urandom_range(6, 1));
               endcase
               send_request(ptt_pkg::CMD_START, id, per, 1'($urandom));
            end else if (pick < 40) begin
               if (tbl_size > 0 && $urandom_range(3) != 0)
                  id = tbl_id[$urandom_range(tbl_size - 1)];
               else
                  id = ptt_pkg::ID_W'($urandom);
               send_request(ptt_pkg::CMD_STOP, id, ptt_pkg::PERIOD_W'($urandom),
                            1'($urandom));
            end else if (pick < 80) begin
               send_overflows(1);
            end else begin
               send_request(ptt_pkg::CMD_DISPATCH, ptt_pkg::ID_W'($urandom),
                            ptt_pkg::PERIOD_W'($urandom), 1'($urandom));
            end
            if ($urandom_range(49) == 0) wait_for_idle();
         end
      end
      steady = 1'b0;
      wait_for_idle();
   endtask

   // receiver stalls
   always @(posedge clock)
      rsp_stall <= !steady && ($urandom_range(99) < 15);

   // compare each response transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_responses.size() == 0) begin
            report_mismatch("response with nothing pending");
         end else begin
            want = pending_responses.pop_front();
            rsp_checked++;
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status %0d, wanted %0d", rsp_status, want.status));
            if (rsp_fired !== want.fired)
               report_mismatch($sformatf("fired %0b, wanted %0b", rsp_fired, want.fired));
            if (rsp_fired_task_id !== want.task_id)
               report_mismatch($sformatf("fired id %0h, wanted %0h",
                                         rsp_fired_task_id, want.task_id));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0b, wanted %0b", rsp_last, want.last));
            if (want.fired) due_seen++;
            if (want.status == ptt_pkg::ST_FULL) full_seen++;
            if (want.status == ptt_pkg::ST_NOT_FOUND) missing_seen++;
         end
      end
   end

   // test sequence
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_fill_and_dispatch();
      test_resolution_changes();
      test_long_period();
      test_random_traffic();
      repeat (16) @(posedge clock);
      if (pending_responses.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", pending_responses.size()));
      $display("covered %0d requests and %0d responses: %0d due reports,",
               items_sent, rsp_checked, due_seen);
      $display("%0d table-full and %0d not-found replies, resolutions 0 to 255, long period",
               full_seen, missing_seen);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // overall time limit
   initial begin
      #20000000;
      $display("timed out with %0d responses outstanding", pending_responses.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
